// File: hw/rtl/lattice_value_noise_assert.svh
// Assertion macros shared by the lattice value noise RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef LATTICE_VALUE_NOISE_ASSERT_SVH
`define LATTICE_VALUE_NOISE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LVN_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LVN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);
`else
`define LVN_ASSERT(lbl, cond, msg)
`define LVN_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/lvn_pkg.sv
// Shared types, constants and hash helpers for lattice value noise.
// No dependencies.
package lvn_pkg;

  localparam int COORD_W = 40;
  localparam int VAL_W   = 18;
  localparam int K_W     = 3;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int PERIOD_BITS_DEF = 20;
  localparam int OCTAVES_DEF     = 5;

  localparam logic [31:0] H_SEED = 32'h811c9dc5;
  localparam logic [31:0] C_X    = 32'h9e3779b9;
  localparam logic [31:0] C_Y    = 32'h85ebca6b;
  localparam logic [31:0] C_Z    = 32'hc2b2ae35;
  localparam logic [31:0] M_A    = 32'h7feb352d;
  localparam logic [31:0] M_B    = 32'h846ca68b;

  typedef enum logic [1:0] {
    CMD_NOISE2 = 2'd0,
    CMD_NOISE3 = 2'd1,
    CMD_FBM2   = 2'd2,
    CMD_FBM3   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic           three;
    logic           fbm;
    logic           first;
    logic           last;
    logic [K_W-1:0] oct;
  } tag_t;

  function automatic logic [31:0] pre_mix(logic [31:0] h, logic [31:0] x, logic [31:0] c);
    logic [31:0] p;
    p = h ^ (x + c + (h << 6) + (h >> 2));
    return p ^ (p >> 16);
  endfunction

  function automatic logic [31:0] mid_mix(logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

  function automatic logic [31:0] fin_mix(logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic signed [VAL_W-1:0] corner_val(logic [31:0] h);
    logic [49:0] n;
    logic [32:0] s;
    logic [17:0] q;
    n = {h, 17'b0} + 50'h7fffffff;
    s = 33'(n[49:32]) + 33'(n[31:0]);
    q = n[49:32] + 18'(s >= 33'hffffffff);
    return signed'(q - 18'd65536);
  endfunction

endpackage

// File: hw/rtl/lattice_value_noise.sv
// Top level of the lattice value noise block: octave sequencer, fbm sum and scale.
// Depends on lvn_pkg, lvn_core and lattice_value_noise_assert.svh.
//
// Usage:
//   An item (in_command, in_coord_x/y/z) is taken at a rising edge with start high
//   and busy low. Noise commands never raise busy, so a new noise item can be
//   taken every cycle. Fbm commands issue OCTAVES octaves (5 by default) into
//   the same pipeline, one per cycle, and hold busy high until the last one is
//   issued, so no new item is taken while an fbm item is still issuing.
//   The pipeline is 14 stages, followed by 3 stages of octave sum and the
//   multiply-by-reciprocal divide by 2^OCTAVES-1.
//   out_strobe pulses once per item; for an fbm item it follows the last octave
//   through the pipeline and the sum and divide stages.
//   Each result sits on out_noise_value for exactly one cycle with out_strobe
//   high; the receiver cannot stall, and the block never holds results.
//   Results leave in the order items were taken.
//   Synchronous reset drops every item in flight and clears busy.
module lattice_value_noise #(
  parameter int FRAC_BITS   = lvn_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_BITS = lvn_pkg::PERIOD_BITS_DEF,
  parameter int OCTAVES     = lvn_pkg::OCTAVES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_command,
  input  logic signed [lvn_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [lvn_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [lvn_pkg::COORD_W-1:0]  in_coord_z,
  output logic                                out_strobe,
  output logic signed [lvn_pkg::VAL_W-1:0]    out_noise_value
);
  import lvn_pkg::*;
  `include "lattice_value_noise_assert.svh"

  localparam int AW      = VAL_W + OCTAVES;
  localparam int DEN     = (1 << OCTAVES) - 1;
  localparam int DIV_LAT = 3;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DEN);
  localparam logic [K_W-1:0] K_LAST = K_W'(OCTAVES - 1);

  logic                      act_r, act_nxt;
  logic [K_W-1:0]            k_r, k_nxt;
  logic                      three_r, fbm_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic                      accept, iss_last;
  cmd_t                      cmd;
  tag_t                      iss_tag;

  logic                      co_vld;
  tag_t                      co_tag;
  logic signed [VAL_W-1:0]   co_value;

  logic signed [AW-1:0]      term, acc_r, acc_nxt;
  logic                      d1_vld_r, d1_fbm_r;
  logic signed [AW-1:0]      d1_val_r;
  logic [AW-1:0]             d1_mag;
  logic                      d2_vld_r, d2_fbm_r, d2_neg_r;
  logic [AW-1:0]             d2_mag_r;
  logic signed [VAL_W-1:0]   d2_byp_r;
  logic [AW+32:0]            d2_prod_r;
  logic [AW-1:0]             d3_q, d3_rem;
  logic [AW-1:0]             d3_qc;
  logic                      out_strobe_r;
  logic signed [VAL_W-1:0]   out_value_r;

  assign cmd      = cmd_t'(in_command);
  assign iss_last = !fbm_r || (k_r == K_LAST);
  assign busy     = act_r && !iss_last;
  assign accept   = start && !busy;

  always_comb begin
    act_nxt = act_r;
    k_nxt   = k_r;
    if (accept) begin
      act_nxt = 1'b1;
      k_nxt   = '0;
    end else if (act_r && iss_last) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      k_nxt = k_r + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      k_r   <= '0;
    end else begin
      act_r <= act_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      three_r <= (cmd == CMD_NOISE3) || (cmd == CMD_FBM3);
      fbm_r   <= (cmd == CMD_FBM2) || (cmd == CMD_FBM3);
      cx_r    <= in_coord_x;
      cy_r    <= in_coord_y;
      cz_r    <= in_coord_z;
    end
  end

  assign iss_tag = '{three: three_r, fbm: fbm_r, first: (k_r == '0), last: iss_last,
                     oct: k_r};

  lvn_core #(
    .FRAC_BITS   (FRAC_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss_vld  (act_r),
    .iss_tag  (iss_tag),
    .iss_x    (cx_r),
    .iss_y    (cy_r),
    .iss_z    (cz_r),
    .co_vld   (co_vld),
    .co_tag   (co_tag),
    .co_value (co_value)
  );

  always_comb begin
    term    = co_tag.fbm ? (AW'(co_value) <<< (K_LAST - co_tag.oct)) : AW'(co_value);
    acc_nxt = co_tag.first ? term : acc_r + term;
    d1_mag  = d1_val_r[AW-1] ? AW'(-d1_val_r) : AW'(d1_val_r);
    d3_q    = d2_prod_r[AW+31:32];
    d3_rem  = d2_mag_r - AW'((d3_q << OCTAVES) - d3_q);
    d3_qc   = (d3_rem >= AW'(DEN)) ? d3_q + AW'(1) : d3_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r     <= 1'b0;
      d2_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      d1_vld_r     <= co_vld && co_tag.last;
      d2_vld_r     <= d1_vld_r;
      out_strobe_r <= d2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (co_vld) begin
      acc_r <= acc_nxt;
    end
    d1_val_r  <= acc_nxt;
    d1_fbm_r  <= co_tag.fbm;
    d2_fbm_r  <= d1_fbm_r;
    d2_neg_r  <= d1_val_r[AW-1];
    d2_mag_r  <= d1_mag + AW'(DEN / 2);
    d2_byp_r  <= d1_val_r[VAL_W-1:0];
    d2_prod_r <= (AW+33)'(d1_mag + AW'(DEN / 2)) * (AW+33)'(RECIP);
    if (!d2_fbm_r) begin
      out_value_r <= d2_byp_r;
    end else if (d2_neg_r) begin
      out_value_r <= VAL_W'(-d3_qc);
    end else begin
      out_value_r <= VAL_W'(d3_qc);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_noise_value = out_value_r;

  `LVN_ASSERT_IMP(a_oct_advance, act_r && (k_r != '0), ($past(act_r) && (k_r == K_W'($past(k_r) + K_W'(1)))), "octave index skipped")
  `LVN_ASSERT_IMP(a_last_to_out, co_vld && co_tag.last, ##DIV_LAT out_strobe, "result strobe lost")
  `LVN_ASSERT_IMP(a_out_range, out_strobe, ((out_noise_value >= -18'sd65536) && (out_noise_value <= 18'sd65536)), "result out of range")

endmodule

// File: hw/rtl/lvn_core.sv
// Lattice noise pipeline: split, corner hash, fade and trilinear blend (bilinear for 2D items).
// One octave enters per cycle; 14 register stages. Depends on lvn_pkg.
module lvn_core #(
  parameter int FRAC_BITS   = lvn_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_BITS = lvn_pkg::PERIOD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   iss_vld,
  input  lvn_pkg::tag_t                          iss_tag,
  input  logic signed [lvn_pkg::COORD_W-1:0]     iss_x,
  input  logic signed [lvn_pkg::COORD_W-1:0]     iss_y,
  input  logic signed [lvn_pkg::COORD_W-1:0]     iss_z,
  output logic                                   co_vld,
  output lvn_pkg::tag_t                          co_tag,
  output logic signed [lvn_pkg::VAL_W-1:0]       co_value
);
  import lvn_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int RW  = PERIOD_BITS + FRAC_BITS;
  localparam int QW  = 2 * F + 4;
  localparam int PW  = F + 21;
  localparam int NS  = 14;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic                      vld_r [1:NS];
  tag_t                      tag_r [1:NS];

  logic signed [COORD_W-1:0] crd    [3];
  logic                      neg_w  [3];
  logic [COORD_W-1:0]        mag_w  [3];
  logic [COORD_W+RW-1:0]     ms_w   [3];
  logic [RW-1:0]             r_w    [3];
  logic [PERIOD_BITS-1:0]    q_w    [3];
  logic [F-1:0]              rem_w  [3];
  logic [31:0]               base_nxt [3];
  logic [F-1:0]              frac_nxt [3];

  logic [31:0]  b_r   [1:5][3];
  logic [F-1:0] t1_r  [3];
  logic [F-1:0] t2_r  [3];
  logic [2*F-1:0] tt_r [3];
  logic [2*F-1:0] t3p_r [3];
  logic [F+3:0] qf_r  [3];
  logic [QW-1:0] q_nxt [3];
  logic [QW-1:0] wp_r [3];
  logic [F:0]   w_r   [5:12][3];

  logic [31:0] h2_r [8];
  logic [31:0] h3_r [8];
  logic [31:0] h4_r [8];
  logic [31:0] h5_r [8];
  logic [31:0] h6_r [8];
  logic [31:0] h7_r [8];
  logic signed [VAL_W-1:0] v8_r [8];

  logic signed [PW-1:0]    px_r  [4];
  logic signed [VAL_W-1:0] a9_r  [4];
  logic signed [VAL_W-1:0] lx_r  [4];
  logic signed [PW-1:0]    py_r  [2];
  logic signed [VAL_W-1:0] a11_r [2];
  logic signed [VAL_W-1:0] ly_r  [2];
  logic signed [PW-1:0]    pz_r;
  logic signed [VAL_W-1:0] a13_r;
  logic signed [VAL_W-1:0] out_r;

  function automatic logic signed [PW-1:0] bl_mul(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b,
                                                   logic [F:0] w);
    logic signed [PW-1:0] d;
    logic signed [PW-1:0] ws;
    d  = PW'(b) - PW'(a);
    ws = signed'(PW'(w));
    return d * ws;
  endfunction

  function automatic logic signed [VAL_W-1:0] bl_add(logic signed [VAL_W-1:0] a,
                                                      logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = PW'(a) + ((p + signed'(PW'(ONE >> 1))) >>> F);
    return s[VAL_W-1:0];
  endfunction

  assign crd[0] = iss_x;
  assign crd[1] = iss_y;
  assign crd[2] = iss_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      neg_w[a] = crd[a][COORD_W-1];
      mag_w[a] = neg_w[a] ? COORD_W'(-crd[a]) : COORD_W'(crd[a]);
      ms_w[a]  = {{RW{1'b0}}, mag_w[a]} << iss_tag.oct;
      r_w[a]   = ms_w[a][RW-1:0];
      q_w[a]   = r_w[a][RW-1:F];
      rem_w[a] = r_w[a][F-1:0];
      if (!neg_w[a]) begin
        base_nxt[a] = 32'(q_w[a]);
        frac_nxt[a] = rem_w[a];
      end else if (rem_w[a] == '0) begin
        base_nxt[a] = 32'd0 - 32'(q_w[a]);
        frac_nxt[a] = '0;
      end else begin
        base_nxt[a] = 32'd0 - 32'(q_w[a]) - 32'd1;
        frac_nxt[a] = F'(ONE - (F+1)'(rem_w[a]));
      end
    end
    if (!iss_tag.three) begin
      base_nxt[2] = '0;
      frac_nxt[2] = '0;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      q_nxt[a] = (QW'(tt_r[a]) << 2) + (QW'(tt_r[a]) << 1) + (QW'(10) << (2 * F))
               - (QW'(t2_r[a]) << F) * QW'(15);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NS; s++) vld_r[s] <= 1'b0;
    end else begin
      vld_r[1] <= iss_vld;
      for (int s = 2; s <= NS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_r[1] <= iss_tag;
    for (int s = 2; s <= NS; s++) tag_r[s] <= tag_r[s-1];

    for (int a = 0; a < 3; a++) begin
      b_r[1][a] <= base_nxt[a];
      for (int s = 2; s <= 5; s++) b_r[s][a] <= b_r[s-1][a];
      t1_r[a]  <= frac_nxt[a];
      tt_r[a]  <= (2*F)'(t1_r[a]) * (2*F)'(t1_r[a]);
      t2_r[a]  <= t1_r[a];
      t3p_r[a] <= (2*F)'(tt_r[a][2*F-1:F]) * (2*F)'(t2_r[a]);
      qf_r[a]  <= q_nxt[a][QW-1:F];
      wp_r[a]  <= QW'(t3p_r[a][2*F-1:F]) * QW'(qf_r[a]);
      w_r[5][a] <= wp_r[a][2*F:F];
      for (int s = 6; s <= 12; s++) w_r[s][a] <= w_r[s-1][a];
    end

    for (int i = 0; i < 8; i++) begin
      h2_r[i] <= pre_mix(H_SEED, b_r[1][0] + 32'(i & 1), C_X) * M_A;
      h3_r[i] <= mid_mix(h2_r[i]) * M_B;
      h4_r[i] <= pre_mix(fin_mix(h3_r[i]), b_r[3][1] + 32'((i >> 1) & 1), C_Y) * M_A;
      h5_r[i] <= mid_mix(h4_r[i]) * M_B;
      h6_r[i] <= pre_mix(fin_mix(h5_r[i]), b_r[5][2] + 32'((i >> 2) & 1), C_Z) * M_A;
      h7_r[i] <= mid_mix(h6_r[i]) * M_B;
      v8_r[i] <= corner_val(fin_mix(h7_r[i]));
    end

    for (int j = 0; j < 4; j++) begin
      px_r[j] <= bl_mul(v8_r[2*j], v8_r[2*j+1], w_r[8][0]);
      a9_r[j] <= v8_r[2*j];
      lx_r[j] <= bl_add(a9_r[j], px_r[j]);
    end
    for (int j = 0; j < 2; j++) begin
      py_r[j]  <= bl_mul(lx_r[2*j], lx_r[2*j+1], w_r[10][1]);
      a11_r[j] <= lx_r[2*j];
      ly_r[j]  <= bl_add(a11_r[j], py_r[j]);
    end
    pz_r  <= bl_mul(ly_r[0], ly_r[1], w_r[12][2]);
    a13_r <= ly_r[0];
    out_r <= tag_r[13].three ? bl_add(a13_r, pz_r) : a13_r;
  end

  assign co_vld   = vld_r[NS];
  assign co_tag   = tag_r[NS];
  assign co_value = out_r;

endmodule
